[rtl/mck_pkg.sv]
`default_nettype none

package mck_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned UnitW      = 16;
  localparam int unsigned DurW       = 19;
  localparam int unsigned PatW       = 5;
  localparam int unsigned LenW       = 3;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam logic [UnitW-1:0] UnitTicksReset = 16'd1000;
  localparam logic [0:0] RegUnitTicks = 1'b0;

  typedef enum logic [1:0] {
    K_MORSE,
    K_SPACE,
    K_OTHER
  } kind_t;

  // Elements are stored in written order from the top bit down; a set bit is a dash.
  typedef struct packed {
    kind_t             kind;
    logic [LenW-1:0]   len;
    logic [PatW-1:0]   pat;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic desc_t classify(input logic [CharW-1:0] c);
    desc_t d;
    d.kind = K_MORSE;
    d.len  = 3'd0;
    d.pat  = 5'b00000;
    case (c)
      8'h61: begin d.len = 3'd2; d.pat = 5'b01000; end
      8'h62: begin d.len = 3'd4; d.pat = 5'b10000; end
      8'h63: begin d.len = 3'd4; d.pat = 5'b10100; end
      8'h64: begin d.len = 3'd3; d.pat = 5'b10000; end
      8'h65: begin d.len = 3'd1; d.pat = 5'b00000; end
      8'h66: begin d.len = 3'd4; d.pat = 5'b00100; end
      8'h67: begin d.len = 3'd3; d.pat = 5'b11000; end
      8'h68: begin d.len = 3'd4; d.pat = 5'b00000; end
      8'h69: begin d.len = 3'd2; d.pat = 5'b00000; end
      8'h6a: begin d.len = 3'd4; d.pat = 5'b01110; end
      8'h6b: begin d.len = 3'd3; d.pat = 5'b10100; end
      8'h6c: begin d.len = 3'd4; d.pat = 5'b01000; end
      8'h6d: begin d.len = 3'd2; d.pat = 5'b11000; end
      8'h6e: begin d.len = 3'd2; d.pat = 5'b10000; end
      8'h6f: begin d.len = 3'd3; d.pat = 5'b11100; end
      8'h70: begin d.len = 3'd4; d.pat = 5'b01100; end
      8'h71: begin d.len = 3'd4; d.pat = 5'b11010; end
      8'h72: begin d.len = 3'd3; d.pat = 5'b01000; end
      8'h73: begin d.len = 3'd3; d.pat = 5'b00000; end
      8'h74: begin d.len = 3'd1; d.pat = 5'b10000; end
      8'h75: begin d.len = 3'd3; d.pat = 5'b00100; end
      8'h76: begin d.len = 3'd4; d.pat = 5'b00010; end
      8'h77: begin d.len = 3'd3; d.pat = 5'b01100; end
      8'h78: begin d.len = 3'd4; d.pat = 5'b10010; end
      8'h79: begin d.len = 3'd4; d.pat = 5'b10110; end
      8'h7a: begin d.len = 3'd4; d.pat = 5'b11000; end
      8'h30: begin d.len = 3'd5; d.pat = 5'b11111; end
      8'h31: begin d.len = 3'd5; d.pat = 5'b01111; end
      8'h32: begin d.len = 3'd5; d.pat = 5'b00111; end
      8'h33: begin d.len = 3'd5; d.pat = 5'b00011; end
      8'h34: begin d.len = 3'd5; d.pat = 5'b00001; end
      8'h35: begin d.len = 3'd5; d.pat = 5'b00000; end
      8'h36: begin d.len = 3'd5; d.pat = 5'b10000; end
      8'h37: begin d.len = 3'd5; d.pat = 5'b11000; end
      8'h38: begin d.len = 3'd5; d.pat = 5'b11100; end
      8'h39: begin d.len = 3'd5; d.pat = 5'b11110; end
      8'h20: d.kind = K_SPACE;
      default: d.kind = K_OTHER;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/mck_front.sv]
`default_nettype none

module mck_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire logic [mck_pkg::CharW-1:0] char_code,
  output logic                          full,
  input  wire mck_pkg::fifo_stat_t      fifo_stat,
  output logic                          wr_valid,
  output mck_pkg::desc_t                wr_desc
);
  import mck_pkg::*;

  logic  valid_r, valid_nxt;
  desc_t desc_r;
  logic  take;
  logic  drain;

  assign full  = valid_r && fifo_stat.full;
  assign take  = push && !full;
  assign drain = valid_r && !fifo_stat.full;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc_r <= classify(char_code);
    end
  end

  assign wr_valid = drain;
  assign wr_desc  = desc_r;

endmodule

`default_nettype wire

[rtl/mck_fifo.sv]
`default_nettype none

module mck_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_valid,
  input  wire mck_pkg::desc_t       wr_desc,
  input  wire logic                 rd_pop,
  output mck_pkg::desc_t            rd_desc,
  output mck_pkg::fifo_stat_t       stat
);
  import mck_pkg::*;

  desc_t      mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr;
  logic       do_rd;

  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;
  assign do_wr      = wr_valid && !stat.full;
  assign do_rd      = rd_pop && !stat.empty;
  assign rd_desc    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_wr ? ~wptr_r : wptr_r;
    rptr_nxt  = do_rd ? ~rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_desc;
    end
  end

endmodule

`default_nettype wire

[rtl/mck_back.sv]
`default_nettype none

module mck_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [mck_pkg::UnitW-1:0] unit_ticks,
  input  wire mck_pkg::fifo_stat_t       fifo_stat,
  input  wire mck_pkg::desc_t            rd_desc,
  output logic                           rd_pop,
  output logic                           empty,
  input  wire logic                      pop,
  output logic                           line_level,
  output logic [mck_pkg::DurW-1:0]       duration_ticks,
  output logic                           last_segment
);
  import mck_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ON,
    S_OFF,
    S_SPACE,
    S_GAP
  } state_t;

  state_t          state_r;
  logic [PatW-1:0] pat_r;
  logic [LenW-1:0] left_r;
  logic            out_valid_r;
  logic [DurW-1:0] x1, x3, x7;
  logic            can_load;
  logic            emit;

  assign x1       = {3'b000, unit_ticks};
  assign x3       = {2'b00, unit_ticks, 1'b0} + x1;
  assign x7       = {unit_ticks, 3'b000} - x1;
  assign can_load = !out_valid_r || pop;
  assign emit     = can_load && (state_r != S_IDLE);
  assign rd_pop   = (state_r == S_IDLE) && !fifo_stat.empty;
  assign empty    = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit || (out_valid_r && !pop);
      unique case (state_r)
        S_IDLE: begin
          if (!fifo_stat.empty) begin
            pat_r  <= rd_desc.pat;
            left_r <= rd_desc.len;
            unique case (rd_desc.kind)
              K_MORSE: state_r <= S_ON;
              K_SPACE: state_r <= S_SPACE;
              default: state_r <= S_GAP;
            endcase
          end
        end
        S_ON: begin
          if (can_load) begin
            line_level     <= 1'b1;
            duration_ticks <= pat_r[PatW-1] ? x3 : x1;
            last_segment   <= 1'b0;
            state_r        <= S_OFF;
          end
        end
        S_OFF: begin
          if (can_load) begin
            line_level     <= 1'b0;
            duration_ticks <= x1;
            last_segment   <= 1'b0;
            pat_r          <= {pat_r[PatW-2:0], 1'b0};
            left_r         <= left_r - 3'd1;
            state_r        <= (left_r == 3'd1) ? S_GAP : S_ON;
          end
        end
        S_SPACE: begin
          if (can_load) begin
            line_level     <= 1'b0;
            duration_ticks <= x7;
            last_segment   <= 1'b0;
            state_r        <= S_GAP;
          end
        end
        S_GAP: begin
          if (can_load) begin
            line_level     <= 1'b0;
            duration_ticks <= x3;
            last_segment   <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/morse_character_keyer_core.sv]
// Channel   Handshake          Payload
// input     push / full        in_char_code
// result    empty / pop        out_line_level, out_duration_ticks, out_last_segment
// config    psel/penable/...   paddr, pwdata, prdata (unit_ticks at address 0)
//
// Each segment leaves the sequencer from its own state, and each character also passes
// through S_IDLE while its descriptor is loaded; a character yields 1 to 11 segments.
// Reset is synchronous and active low; it empties the queue and restores unit_ticks.
// A low pop stalls the sequencer; the front register and a two-entry queue keep
// accepting characters until both are occupied.
`default_nettype none

module morse_character_keyer_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [mck_pkg::CharW-1:0] in_char_code,
  output logic                           empty,
  input  wire logic                      pop,
  output logic                           out_line_level,
  output logic [mck_pkg::DurW-1:0]       out_duration_ticks,
  output logic                           out_last_segment,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mck_pkg::AddrW-1:0] paddr,
  input  wire logic [mck_pkg::DataW-1:0] pwdata,
  output logic [mck_pkg::DataW-1:0]      prdata,
  output logic                           pready
);
  import mck_pkg::*;

  logic [UnitW-1:0] unit_ticks_r;
  fifo_stat_t       fifo_stat;
  logic             wr_valid;
  desc_t            wr_desc;
  desc_t            rd_desc;
  logic             rd_pop;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[AddrW-1] == RegUnitTicks);
  assign prdata = (paddr[AddrW-1] == RegUnitTicks) ? {16'd0, unit_ticks_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UnitTicksReset;
    end else if (cfg_wr) begin
      unit_ticks_r <= pwdata[UnitW-1:0];
    end
  end

  mck_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .char_code (in_char_code),
    .full      (full),
    .fifo_stat (fifo_stat),
    .wr_valid  (wr_valid),
    .wr_desc   (wr_desc)
  );

  mck_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_desc  (wr_desc),
    .rd_pop   (rd_pop),
    .rd_desc  (rd_desc),
    .stat     (fifo_stat)
  );

  mck_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .unit_ticks     (unit_ticks_r),
    .fifo_stat      (fifo_stat),
    .rd_desc        (rd_desc),
    .rd_pop         (rd_pop),
    .empty          (empty),
    .pop            (pop),
    .line_level     (out_line_level),
    .duration_ticks (out_duration_ticks),
    .last_segment   (out_last_segment)
  );

`ifndef SYNTHESIS
  a_gap_is_off: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_last_segment |-> !out_line_level)
    else $error("character gap keyed on");

  a_gap_length: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_last_segment |->
      out_duration_ticks == ({3'b000, unit_ticks_r} + {2'b00, unit_ticks_r, 1'b0}))
    else $error("character gap is not three units");

  a_full_means_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> fifo_stat.full)
    else $error("input stalled with room in the queue");

  a_reset_unit: assert property (@(posedge clk)
    $rose(rst_n) |-> unit_ticks_r == UnitTicksReset)
    else $error("unit length not restored by reset");
`endif

endmodule

`default_nettype wire

[sim/morse_character_keyer_core_tb.sv]
`default_nettype none

module morse_character_keyer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mck_pkg::*;

  localparam bit LineOn = 1'b1;
  localparam bit LineOff = 1'b0;
  localparam int unsigned DotUnits = 1;
  localparam int unsigned DashUnits = 3;
  localparam int unsigned ElemGapUnits = 1;
  localparam int unsigned CharGapUnits = 3;
  localparam int unsigned WordGapUnits = 7;
  localparam logic [7:0] SpaceCode = 8'h20;
  localparam logic [AddrW-1:0] UnitTicksAddr = AddrW'(4 * RegUnitTicks);
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 16;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] dur;
    logic            last;
  } segment_t;

  class keying_scoreboard;
    logic [UnitW-1:0] unit_ticks;
    segment_t         segments_due[$];
    int               errors;

    function new();
      unit_ticks = UnitTicksReset;
      errors = 0;
    endfunction

    function void set_unit(logic [UnitW-1:0] v);
      unit_ticks = v;
    endfunction

    function int pending();
      return segments_due.size();
    endfunction

    function string pattern_of(logic [7:0] c);
      case (c)
        "a": return ".-";
        "b": return "-...";
        "c": return "-.-.";
        "d": return "-..";
        "e": return ".";
        "f": return "..-.";
        "g": return "--.";
        "h": return "....";
        "i": return "..";
        "j": return ".---";
        "k": return "-.-";
        "l": return ".-..";
        "m": return "--";
        "n": return "-.";
        "o": return "---";
        "p": return ".--.";
        "q": return "--.-";
        "r": return ".-.";
        "s": return "...";
        "t": return "-";
        "u": return "..-";
        "v": return "...-";
        "w": return ".--";
        "x": return "-..-";
        "y": return "-.--";
        "z": return "--..";
        "0": return "-----";
        "1": return ".----";
        "2": return "..---";
        "3": return "...--";
        "4": return "....-";
        "5": return ".....";
        "6": return "-....";
        "7": return "--...";
        "8": return "---..";
        "9": return "----.";
        default: return "";
      endcase
    endfunction

    function void add_segment(logic level, int unsigned units, logic last);
      segment_t s;
      s.level = level;
      s.dur = DurW'(units * unit_ticks);
      s.last = last;
      segments_due.push_back(s);
    endfunction

    function void note_char(logic [7:0] c);
      string p;
      p = pattern_of(c);
      for (int i = 0; i < p.len(); i++) begin
        add_segment(LineOn, (p[i] == "-") ? DashUnits : DotUnits, 1'b0);
        add_segment(LineOff, ElemGapUnits, 1'b0);
      end
      if (p.len() == 0 && c == SpaceCode) begin
        add_segment(LineOff, WordGapUnits, 1'b0);
      end
      add_segment(LineOff, CharGapUnits, 1'b1);
    endfunction

    function void check_segment(logic level, logic [DurW-1:0] dur, logic last);
      segment_t e;
      if (segments_due.size() == 0) begin
        $display("%0t: segment with nothing expected: level %0b duration %0d last %0b",
                 $time, level, dur, last);
        errors++;
        return;
      end
      e = segments_due.pop_front();
      if (level !== e.level) begin
        $display("%0t: line_level expected %0b actual %0b", $time, e.level, level);
        errors++;
      end
      if (dur !== e.dur) begin
        $display("%0t: duration_ticks expected %0d actual %0d", $time, e.dur, dur);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_segment expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [CharW-1:0]  in_char_code = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              out_line_level;
  logic [DurW-1:0]   out_duration_ticks;
  logic              out_last_segment;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  keying_scoreboard board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  morse_character_keyer_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_char_code(in_char_code),
    .empty(empty),
    .pop(pop),
    .out_line_level(out_line_level),
    .out_duration_ticks(out_duration_ticks),
    .out_last_segment(out_last_segment),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        board.check_segment(out_line_level, out_duration_ticks, out_last_segment);
      end
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_char(input logic [CharW-1:0] c);
    if ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    push <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (full);
    board.note_char(c);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_unit(input logic [DataW-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= UnitTicksAddr;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_unit(v[UnitW-1:0]);
  endtask

  function automatic logic [CharW-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CharW'("a" + $urandom_range(0, 25));
    if (r < 70) return CharW'("0" + $urandom_range(0, 9));
    if (r < 80) return SpaceCode;
    return CharW'($urandom_range(0, 255));
  endfunction

  task automatic run_random(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_char(pick_char());
    drain();
  endtask

  initial begin
    logic [CharW-1:0] directed[$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset unit length, then a zero unit length.
    directed = '{"a", "z", "0", "9", "e", "t", "5", " ", "A", "Z", "/",
                 8'h00, 8'h7f, 8'h80, 8'hff, "q", "y"};
    foreach (directed[i]) send_char(directed[i]);
    drain();
    write_unit(32'd0);
    directed = '{"0", " ", "x", 8'h41};
    foreach (directed[i]) send_char(directed[i]);
    drain();

    write_unit(32'd1);
    run_random(75, 0, 0);
    write_unit(32'd65535);
    run_random(75, 50, 0);
    write_unit({16'hA5C3, 16'($urandom_range(1, 65535))});
    run_random(75, 0, 50);
    write_unit(32'($urandom_range(1, 65535)));
    run_random(75, 10, 10);

    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/mck_pkg.sv
rtl/mck_front.sv
rtl/mck_fifo.sv
rtl/mck_back.sv
rtl/morse_character_keyer_core.sv
sim/morse_character_keyer_core_tb.sv
